### design/tak_pkg.sv
package tak_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQR_A,
        ST_SQR_B,
        ST_SQRT,
        ST_CORDIC,
        ST_PREDICT,
        ST_GAIN,
        ST_CORR_MUL,
        ST_CORR_ADD,
        ST_VAR_MUL,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        REG_STEP_TIME = 2'd0,
        REG_PROC_VAR  = 2'd1,
        REG_MEAS_VAR  = 2'd2
    } t_reg_index;

    localparam logic [15:0] STEP_TIME_RESET = 16'd13107;
    localparam logic [31:0] PROC_VAR_RESET  = 32'd41943;
    localparam logic [31:0] MEAS_VAR_RESET  = 32'd589824;
    localparam logic [31:0] VAR_RESET       = 32'd262144;

    function automatic logic [31:0] atan_deg(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd2949120;
            5'd1:  v = 32'd1740967;
            5'd2:  v = 32'd919879;
            5'd3:  v = 32'd466945;
            5'd4:  v = 32'd234379;
            5'd5:  v = 32'd117304;
            5'd6:  v = 32'd58666;
            5'd7:  v = 32'd29335;
            5'd8:  v = 32'd14668;
            5'd9:  v = 32'd7334;
            5'd10: v = 32'd3667;
            5'd11: v = 32'd1833;
            5'd12: v = 32'd917;
            5'd13: v = 32'd458;
            5'd14: v = 32'd229;
            5'd15: v = 32'd115;
            5'd16: v = 32'd57;
            5'd17: v = 32'd29;
            5'd18: v = 32'd14;
            5'd19: v = 32'd7;
            5'd20: v = 32'd4;
            5'd21: v = 32'd2;
            5'd22: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### design/tilt_angle_kalman_filter_core.sv
// Tilt estimator: each transfer of an accelerometer triple and two gyro rates yields one
// filtered roll and pitch pair in 1/128 degree. Each axis runs the bit-serial square root,
// the CORDIC iterations and the 48-step restoring divider, and the two axes run in turn
// before the result is registered and made valid. The input is not ready meanwhile, nor
// while the result waits, so the next transfer comes at the earliest in the cycle after
// the result is taken.
module tilt_angle_kalman_filter_core #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int SAMPLE_WIDTH      = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    input  logic signed [15:0]             i_gyro_roll_rate,
    input  logic signed [15:0]             i_gyro_pitch_rate,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [15:0]             o_roll_angle,
    output logic signed [15:0]             o_pitch_angle,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import tak_pkg::*;

    logic [15:0] r_step_time;
    logic [31:0] r_proc_var, r_meas_var;
    logic        r_busy, r_out_valid;
    logic        w_start, w_done;
    logic signed [15:0] w_roll, w_pitch;
    logic signed [15:0] r_roll, r_pitch;

    assign o_ready = !r_busy && !r_out_valid;
    assign w_start = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RESET;
            r_proc_var  <= PROC_VAR_RESET;
            r_meas_var  <= MEAS_VAR_RESET;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_index'(i_cfg_index))
                    REG_STEP_TIME: r_step_time <= i_cfg_data[15:0];
                    REG_PROC_VAR:  r_proc_var  <= i_cfg_data;
                    REG_MEAS_VAR:  r_meas_var  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_start) r_busy <= 1'b1;
            else if (w_done) r_busy <= 1'b0;
            if (w_done) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_roll  <= w_roll;
            r_pitch <= w_pitch;
        end
    end

    tak_datapath #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .SAMPLE_WIDTH      (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_ax        (i_accel_x),
        .i_ay        (i_accel_y),
        .i_az        (i_accel_z),
        .i_gr        (i_gyro_roll_rate),
        .i_gp        (i_gyro_pitch_rate),
        .i_step_time (r_step_time),
        .i_proc_var  (r_proc_var),
        .i_meas_var  (r_meas_var),
        .o_done      (w_done),
        .o_roll      (w_roll),
        .o_pitch     (w_pitch)
    );

    assign o_valid       = r_out_valid;
    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;
endmodule

### design/tak_divider.sv
module tak_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_busy,
    output logic [16:0] o_quot
);
    logic [32:0] r_rem, n_rem;
    logic [47:0] r_num, n_num;
    logic [16:0] r_quot, n_quot;
    logic [32:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic [33:0] w_trial;

    always_comb begin
        w_trial = {r_rem, r_num[47]};
        n_rem   = r_rem;
        n_num   = r_num;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_rem  = '0;
            n_num  = i_num;
            n_quot = '0;
            n_cnt  = 6'd48;
        end else if (r_cnt != 6'd0) begin
            n_num = {r_num[46:0], 1'b0};
            n_cnt = r_cnt - 6'd1;
            if (w_trial >= {1'b0, r_den}) begin
                n_rem  = 33'(w_trial - {1'b0, r_den});
                n_quot = {r_quot[15:0], 1'b1};
            end else begin
                n_rem  = w_trial[32:0];
                n_quot = {r_quot[15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_quot <= n_quot;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = i_start || (r_cnt != 6'd0);
    assign o_quot = r_quot;
endmodule

### design/tak_datapath.sv
module tak_datapath
    import tak_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int SAMPLE_WIDTH      = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [SAMPLE_WIDTH-1:0] i_ax,
    input  logic signed [SAMPLE_WIDTH-1:0] i_ay,
    input  logic signed [SAMPLE_WIDTH-1:0] i_az,
    input  logic signed [15:0]             i_gr,
    input  logic signed [15:0]             i_gp,
    input  logic [15:0]                    i_step_time,
    input  logic [31:0]                    i_proc_var,
    input  logic [31:0]                    i_meas_var,
    output logic                           o_done,
    output logic signed [15:0]             o_roll,
    output logic signed [15:0]             o_pitch
);
    localparam int SW2 = 2 * SAMPLE_WIDTH;
    localparam int RW  = SW2 + 17;
    localparam int QW  = (RW + 1) / 2 + 1;
    localparam int CW  = QW + 3;
    localparam int IW  = $clog2(CORDIC_ITERATIONS + 1);
    localparam int BW  = $clog2(RW);

    t_state r_state, n_state;
    logic        r_axis;
    logic signed [SAMPLE_WIDTH-1:0] r_ax, r_ay, r_az, w_opp, w_a, w_b;
    logic signed [15:0] r_gr, r_gp;
    logic [RW-1:0] r_rem, r_res;
    logic [BW-1:0] r_bit;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic [IW-1:0] r_iter;
    logic signed [33:0] r_meas;
    logic signed [31:0] r_roll_est, r_pitch_est, r_est;
    logic [31:0] r_roll_var, r_pitch_var, r_p;
    logic signed [50:0] r_prod;
    logic signed [33:0] w_diff;
    logic [16:0] w_quot;
    logic [16:0] w_gain;
    logic        w_div_busy, w_div_start;
    logic [RW-1:0] w_bitv, w_trial;
    logic signed [CW-1:0] w_xs, w_ys;
    logic [32:0] w_psum;
    logic [32:0] w_den;
    logic signed [33:0] w_sum;
    logic signed [31:0] w_sat;
    logic signed [33:0] w_out_r;
    logic signed [15:0] r_out_r, r_out_p;

    assign w_opp = r_axis ? r_ax : r_ay;
    assign w_a   = r_axis ? r_ay : r_ax;
    assign w_b   = r_az;
    assign w_bitv  = RW'(1) << r_bit;
    assign w_trial = r_res + w_bitv;
    assign w_xs  = r_x >>> r_iter;
    assign w_ys  = r_y >>> r_iter;
    assign w_psum = {1'b0, r_p};
    assign w_den  = 33'(w_psum + {1'b0, i_meas_var});
    assign w_gain = (w_den == '0) ? 17'd0 : w_quot;
    assign w_div_start = (r_state == ST_PREDICT);
    assign w_diff = 34'(r_meas - 34'(r_est));

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -34'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    tak_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_p, 16'd0}),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        w_sum   = '0;
        w_sat   = '0;
        unique case (r_state)
            ST_IDLE:     if (i_start) n_state = ST_SQR_A;
            ST_SQR_A:    n_state = ST_SQR_B;
            ST_SQR_B:    n_state = ST_SQRT;
            ST_SQRT:     if (r_bit[0] == 1'b0 && r_bit < BW'(2)) n_state = ST_CORDIC;
            ST_CORDIC:   if (r_iter == IW'(CORDIC_ITERATIONS)) n_state = ST_PREDICT;
            ST_PREDICT:  n_state = ST_GAIN;
            ST_GAIN:     if (!w_div_busy) n_state = ST_CORR_MUL;
            ST_CORR_MUL: n_state = ST_CORR_ADD;
            ST_CORR_ADD: n_state = ST_VAR_MUL;
            ST_VAR_MUL:  n_state = r_axis ? ST_DONE : ST_SQR_A;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
        w_sum = 34'(r_est) + 34'((r_prod + 51'sd32768) >>> 16);
        w_sat = sat32(w_sum);
    end

    assign w_out_r = (34'(r_est) + 34'sd256) >>> 9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_roll_est  <= '0;
            r_pitch_est <= '0;
            r_roll_var  <= VAR_RESET;
            r_pitch_var <= VAR_RESET;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_ax <= i_ax; r_ay <= i_ay; r_az <= i_az;
                        r_gr <= i_gr; r_gp <= i_gp;
                        r_axis <= 1'b0;
                    end
                end
                ST_SQR_A: begin
                    r_prod <= 51'(w_a * w_a);
                end
                ST_SQR_B: begin
                    r_rem <= RW'((r_prod + 51'(w_b * w_b)) << 16);
                    r_res <= '0;
                    r_bit <= BW'(RW - 1 - ((RW - 1) % 2));
                end
                ST_SQRT: begin
                    if (r_rem >= w_trial) begin
                        r_rem <= r_rem - w_trial;
                        r_res <= (r_res >> 1) + w_bitv;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    if (r_bit >= BW'(2)) r_bit <= r_bit - BW'(2);
                    if (r_bit < BW'(2)) begin
                        r_iter <= '0;
                        r_z    <= '0;
                        r_y    <= CW'(w_opp) <<< 8;
                    end
                end
                ST_CORDIC: begin
                    if (r_iter != IW'(CORDIC_ITERATIONS)) begin
                        if (r_y >= 0) begin
                            r_x <= r_x + w_ys; r_y <= r_y - w_xs;
                            r_z <= r_z + 34'(atan_deg(5'(r_iter)));
                        end else begin
                            r_x <= r_x - w_ys; r_y <= r_y + w_xs;
                            r_z <= r_z - 34'(atan_deg(5'(r_iter)));
                        end
                        r_iter <= r_iter + IW'(1);
                    end else begin
                        r_meas <= (r_x == '0 && r_y == '0) ? 34'sd0 :
                                  (r_axis ? -r_z : r_z);
                    end
                end
                ST_PREDICT: begin
                end
                ST_GAIN: begin
                end
                ST_CORR_MUL: begin
                    r_prod <= 51'(w_diff * $signed({1'b0, w_gain}));
                end
                ST_CORR_ADD: begin
                    r_est  <= w_sat;
                    r_prod <= $signed({3'b0, 48'(r_p * 33'(17'h10000 - w_gain))});
                end
                ST_VAR_MUL: begin
                    if (r_axis) begin
                        r_pitch_est <= r_est; r_pitch_var <= r_prod[47:16];
                    end else begin
                        r_roll_est <= r_est; r_roll_var <= r_prod[47:16];
                    end
                    r_axis <= 1'b1;
                end
                ST_DONE: begin
                end
                default: begin
                end
            endcase
            if (r_state == ST_SQRT && r_bit < BW'(2)) begin
                r_x <= (r_rem >= w_trial) ? CW'((r_res >> 1) + w_bitv) : CW'(r_res >> 1);
            end
            if (r_state == ST_CORDIC && r_iter == IW'(CORDIC_ITERATIONS)) begin
                r_est <= sat32(34'(r_axis ? r_pitch_est : r_roll_est)
                    + ((34'($signed({1'b0, i_step_time})) * 34'(r_axis ? r_gp : r_gr)
                        + 34'sd64) >>> 7));
                r_p <= (33'(r_axis ? r_pitch_var : r_roll_var) + 33'(i_proc_var) > 33'hFFFFFFFF)
                    ? 32'hFFFFFFFF : 32'((r_axis ? r_pitch_var : r_roll_var) + i_proc_var);
            end
            if (r_state == ST_VAR_MUL && !r_axis) begin
                r_out_r <= (w_out_r > 34'sd32767) ? 16'sh7FFF :
                           (w_out_r < -34'sd32768) ? 16'sh8000 : w_out_r[15:0];
            end
            if (r_state == ST_VAR_MUL && r_axis) begin
                r_out_p <= (w_out_r > 34'sd32767) ? 16'sh7FFF :
                           (w_out_r < -34'sd32768) ? 16'sh8000 : w_out_r[15:0];
            end
        end
    end

    assign o_done  = (r_state == ST_DONE);
    assign o_roll  = r_out_r;
    assign o_pitch = r_out_p;
endmodule

### design/tak_checker.sv
module tak_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic [15:0] o_roll_angle
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_roll_angle))
        else $error("result dropped while stalled");
    a_no_accept_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after transfer");
    a_no_out_right_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid)
        else $error("result too early");
endmodule

bind tilt_angle_kalman_filter_core tak_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_roll_angle (o_roll_angle)
);
